// File: sv/assert_macros.svh
// Assertion macros for the RTL of the battery report decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define BRD_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Checked on every clock edge, reset cycles included.
`define BRD_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// File: sv/brd_pkg.sv
// Types and constants of the battery report decoder.
`timescale 1ns / 1ps

package brd_pkg;

  // Reply formats.
  localparam logic [1:0] FMT_UNIFIED = 2'd0;
  localparam logic [1:0] FMT_PLAIN   = 2'd1;
  localparam logic [1:0] FMT_VOLTAGE = 2'd2;
  localparam logic [1:0] FMT_UNKNOWN = 2'd3;

  // Coarse charge levels.
  localparam logic [1:0] LVL_EMPTY  = 2'd0;
  localparam logic [1:0] LVL_LOW    = 2'd1;
  localparam logic [1:0] LVL_MEDIUM = 2'd2;
  localparam logic [1:0] LVL_FULL   = 2'd3;

  localparam logic [7:0] LVL_LOW_MIN    = 8'd20;
  localparam logic [7:0] LVL_MEDIUM_MIN = 8'd50;
  localparam logic [7:0] LVL_FULL_MIN   = 8'd80;
  localparam logic [7:0] PCT_MAX        = 8'd100;

  // Unified-format level codes and their percentages.
  localparam logic [7:0] CODE_FULL     = 8'd8;
  localparam logic [7:0] CODE_GOOD     = 8'd4;
  localparam logic [7:0] CODE_LOW      = 8'd2;
  localparam logic [7:0] CODE_CRITICAL = 8'd1;
  localparam logic [7:0] PCT_FULL      = 8'd90;
  localparam logic [7:0] PCT_GOOD      = 8'd50;
  localparam logic [7:0] PCT_LOW       = 8'd20;
  localparam logic [7:0] PCT_CRITICAL  = 8'd5;

  // Status codes 1 to 4 mean charging in the unified and plain formats.
  localparam logic [7:0] STATUS_CHG_MIN = 8'd1;
  localparam logic [7:0] STATUS_CHG_MAX = 8'd4;

  // Discharge curve points in millivolts.
  localparam logic [15:0] MV_P0 = 16'd4180;
  localparam logic [15:0] MV_P1 = 16'd4000;
  localparam logic [15:0] MV_P2 = 16'd3800;
  localparam logic [15:0] MV_P3 = 16'd3700;
  localparam logic [15:0] MV_P4 = 16'd3500;

  // Reciprocal multipliers. Each is exact after the shift over the range of its segment.
  localparam logic [13:0] RECIP_9  = 14'd57;   // x / 9  = (x * 57)  >> 9,  x < 180
  localparam logic [16:0] RECIP_20 = 17'd205;  // x / 20 = (x * 205) >> 12, x < 600
  localparam logic [15:0] RECIP_10 = 16'd205;  // x / 10 = (x * 205) >> 11, x < 300

  typedef struct packed {
    logic [7:0] percent;
    logic [1:0] charge_level;
    logic       charging;
    logic       valid_res;
  } res_t;

endpackage

// File: sv/battery_report_decoder.sv
// Battery report decoder: one reply in, one decoded result out.
// An accepted item is held in the input register and then in the result register,
// which drives the outputs until the result is taken.
// Throughput: one item per cycle while res_stall is low; each register holds one item.
// A stalled result holds while one more item is taken into the input register.
// Reset (synchronous, active high) empties both registers.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module battery_report_decoder
  import brd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] func,
  input  logic [7:0] reply_byte4,
  input  logic [7:0] reply_byte5,
  input  logic [7:0] reply_byte6,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] percent,
  output logic [1:0] charge_level,
  output logic       charging,
  output logic       valid_res
);

  // Input register.
  logic       in_full;
  logic [1:0] in_func;
  logic [7:0] in_b4;
  logic [7:0] in_b5;
  logic [7:0] in_b6;

  // Result register.
  res_t res;

  logic res_load;
  logic in_load;

  assign res_load  = !(res_valid && res_stall);
  assign req_stall = in_full && !res_load;
  assign in_load   = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_load) begin
      in_full <= 1'b1;
    end else if (res_load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_func <= func;
      in_b4   <= reply_byte4;
      in_b5   <= reply_byte5;
      in_b6   <= reply_byte6;
    end
  end

  // Voltage format: piecewise-linear map of millivolts to percent.
  logic [15:0] mv;
  logic [7:0]  d0, d1, d2, d3;
  logic [9:0]  x1;
  logic [8:0]  x2;
  logic [13:0] p0;
  logic [16:0] p1;
  logic [15:0] p2;
  logic [15:0] p3;
  logic [7:0]  volt_pct;

  assign mv = {in_b4, in_b5};
  assign d0 = 8'(mv - MV_P1);
  assign d1 = 8'(mv - MV_P2);
  assign d2 = 8'(mv - MV_P3);
  assign d3 = 8'(mv - MV_P4);
  assign x1 = {2'd0, d1} + {1'b0, d1, 1'b0};
  assign x2 = {1'b0, d2} + {d2, 1'b0};
  assign p0 = {6'd0, d0} * RECIP_9;
  assign p1 = {7'd0, x1} * RECIP_20;
  assign p2 = {7'd0, x2} * RECIP_10;
  assign p3 = {8'd0, d3} * RECIP_10;

  always_comb begin
    if (mv >= MV_P0) begin
      volt_pct = PCT_MAX;
    end else if (mv <= MV_P4) begin
      volt_pct = 8'd0;
    end else if (mv >= MV_P1) begin
      volt_pct = LVL_FULL_MIN + 8'(p0[13:9]);
    end else if (mv >= MV_P2) begin
      volt_pct = LVL_MEDIUM_MIN + 8'(p1[16:12]);
    end else if (mv >= MV_P3) begin
      volt_pct = LVL_LOW_MIN + 8'(p2[15:11]);
    end else begin
      volt_pct = 8'(p3[15:11]);
    end
  end

  // Format selection and result assembly.
  logic [7:0] code_pct;
  logic [7:0] pct;
  logic       chg;
  logic       ok;
  logic       status_chg;
  res_t       res_next;

  assign status_chg = (in_b6 >= STATUS_CHG_MIN) && (in_b6 <= STATUS_CHG_MAX);

  always_comb begin
    case (in_b5)
      CODE_FULL:     code_pct = PCT_FULL;
      CODE_GOOD:     code_pct = PCT_GOOD;
      CODE_LOW:      code_pct = PCT_LOW;
      CODE_CRITICAL: code_pct = PCT_CRITICAL;
      default:       code_pct = 8'd0;
    endcase
  end

  always_comb begin
    pct = 8'd0;
    chg = 1'b0;
    ok  = 1'b1;
    unique case (in_func)
      FMT_UNIFIED: begin
        pct = (in_b4 == 8'd0) ? code_pct : in_b4;
        chg = status_chg;
      end
      FMT_PLAIN: begin
        pct = in_b4;
        chg = status_chg;
      end
      FMT_VOLTAGE: begin
        pct = volt_pct;
        chg = in_b6[7];
      end
      FMT_UNKNOWN: begin
        ok = 1'b0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (pct > PCT_MAX) begin
      ok = 1'b0;
    end

    res_next = '0;
    if (ok) begin
      res_next.percent   = pct;
      res_next.charging  = chg;
      res_next.valid_res = 1'b1;
      if (pct >= LVL_FULL_MIN) begin
        res_next.charge_level = LVL_FULL;
      end else if (pct >= LVL_MEDIUM_MIN) begin
        res_next.charge_level = LVL_MEDIUM;
      end else if (pct >= LVL_LOW_MIN) begin
        res_next.charge_level = LVL_LOW;
      end else begin
        res_next.charge_level = LVL_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  assign percent      = res.percent;
  assign charge_level = res.charge_level;
  assign charging     = res.charging;
  assign valid_res    = res.valid_res;

  `BRD_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !res_valid && !in_full,
                     "reset left an item in the pipeline")
  `BRD_ASSERT(a_invalid_zero, clk, rst,
              res_valid && !valid_res |-> percent == 8'd0 && charge_level == LVL_EMPTY
              && !charging, "invalid result carries nonzero fields")
  `BRD_ASSERT(a_valid_range, clk, rst, res_valid && valid_res |-> percent <= PCT_MAX,
              "valid result above full scale")
  `BRD_ASSERT(a_level_full, clk, rst,
              res_valid && valid_res && percent >= LVL_FULL_MIN |-> charge_level == LVL_FULL,
              "charge level disagrees with percent")

endmodule
